// ----- rtl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix: shared package
// Widths, pipeline depths, item types and saturation helper for the
// fixed-point look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // The largest normalized magnitude of a vector lies in [2^(NW-1), 2^NW).
    localparam int NW  = 30;
    localparam int UW  = FRAC_BITS + 3;
    localparam int QW  = FRAC_BITS + 2;
    localparam int PRW = NW + 1 + UW;
    localparam int IW  = (COORD_WIDTH + 1 > PRW + 1) ? COORD_WIDTH + 1 : PRW + 1;
    localparam int PW  = $clog2(IW);
    localparam logic [PW-1:0] P_TOP = PW'(NW - 1);

    localparam int RTW     = NW + 1;
    localparam int XW      = 2 * RTW;
    localparam int RMW     = RTW + 3;
    localparam int SQ_PER  = 4;
    localparam int SQ_ST   = (RTW + SQ_PER - 1) / SQ_PER;
    localparam int DRW     = RTW + 1;
    localparam int NNW     = NW + FRAC_BITS + 1;
    localparam int DV_PER  = 3;
    localparam int DV_ST   = (QW + DV_PER - 1) / DV_PER;
    localparam int NORM_LAT = 6 + SQ_ST + DV_ST;
    localparam int TOP_LAT  = 2 * NORM_LAT + 9;

    localparam int YPW = 2 * UW;
    localparam int YRW = 2 * UW + 1;
    localparam int DPW = UW + COORD_WIDTH;
    localparam int DSW = (DPW + 2 > YRW) ? DPW + 2 : YRW;

    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef coord_t [2:0]                  coord_vec_t;
    typedef logic signed [IW-1:0]          wide_t;
    typedef wide_t [2:0]                   wide_vec_t;
    typedef logic signed [UW-1:0]          unit_t;
    typedef unit_t [2:0]                   unit_vec_t;
    typedef logic [2:0][NW-1:0]            nmag_vec_t;
    typedef coord_t [3:0]                  column_t;
    typedef column_t [3:0]                 matrix_t;

    typedef struct packed {
        coord_t eye_x;
        coord_t eye_y;
        coord_t eye_z;
        coord_t target_x;
        coord_t target_y;
        coord_t target_z;
        coord_t up_x;
        coord_t up_y;
        coord_t up_z;
    } lav_in_t;

    typedef struct packed {
        logic [1:0] column_index;
        coord_t     entry_row0;
        coord_t     entry_row1;
        coord_t     entry_row2;
        coord_t     entry_row3;
        logic       last_column;
        logic       degenerate;
    } lav_out_t;

    localparam logic signed [DSW-1:0] SAT_HI =
        {{(DSW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [DSW-1:0] SAT_LO = ~SAT_HI;

    function automatic coord_t sat_coord(input logic signed [DSW-1:0] v);
        coord_t res;
        if (v > SAT_HI)
        begin
            res = SAT_HI[COORD_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            res = SAT_LO[COORD_WIDTH-1:0];
        end
        else
        begin
            res = v[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    localparam logic signed [DSW-1:0] ONE_WIDE = DSW'(1) <<< FRAC_BITS;
    localparam coord_t ONE_ENTRY = sat_coord(ONE_WIDE);

endpackage

// ----- rtl/lav_prescale.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix: vector prescaler
// Two-stage scaling of a vector by a power of two so that its largest
// component magnitude lands in [2^29, 2^30); magnitudes and signs come out.
// ----------------------------------------------------------------------------
module lav_prescale (
    input  logic                clk,
    input  logic                adv,
    input  lav_pkg::wide_vec_t  vec,
    output lav_pkg::nmag_vec_t  mag,
    output logic [2:0]          sgn,
    output logic                zero
);

    logic [2:0][lav_pkg::IW-1:0] m_next;
    logic [2:0][lav_pkg::IW-1:0] m1_reg;
    logic [2:0]                  s_next;
    logic [2:0]                  s1_reg;
    logic [lav_pkg::IW-1:0]      any;
    logic [lav_pkg::PW-1:0]      p_next;
    logic [lav_pkg::PW-1:0]      p1_reg;
    logic                        z1_reg;
    logic [lav_pkg::IW-1:0]      sh;
    lav_pkg::nmag_vec_t          w_next;
    lav_pkg::nmag_vec_t          w2_reg;
    logic [2:0]                  s2_reg;
    logic                        z2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = vec[i][lav_pkg::IW-1];
            m_next[i] = s_next[i] ? (~vec[i] + 1'b1) : vec[i];
        end
        any    = m_next[0] | m_next[1] | m_next[2];
        p_next = '0;
        for (int b = 0; b < lav_pkg::IW; b++)
        begin
            if (any[b])
            begin
                p_next = lav_pkg::PW'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= m_next;
            s1_reg <= s_next;
            p1_reg <= p_next;
            z1_reg <= (any == '0);
        end
    end

    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (p1_reg >= lav_pkg::P_TOP)
            begin
                sh = m1_reg[i] >> (p1_reg - lav_pkg::P_TOP);
            end
            else
            begin
                sh = m1_reg[i] << (lav_pkg::P_TOP - p1_reg);
            end
            w_next[i] = sh[lav_pkg::NW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w2_reg <= w_next;
            s2_reg <= s1_reg;
            z2_reg <= z1_reg;
        end
    end

    assign mag  = w2_reg;
    assign sgn  = s2_reg;
    assign zero = z2_reg;

endmodule

// ----- rtl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix: vector normalizer
// Pipelined unit-vector unit: prescale, sum of squares, digit-serial
// square root and restoring division, one item per cycle while adv is high.
// ----------------------------------------------------------------------------
module lav_norm (
    input  logic                clk,
    input  logic                adv,
    input  lav_pkg::wide_vec_t  vec,
    output lav_pkg::unit_vec_t  unit,
    output logic                zero
);

    localparam int NW    = lav_pkg::NW;
    localparam int SQW   = 2 * NW;
    localparam int XW    = lav_pkg::XW;
    localparam int RMW   = lav_pkg::RMW;
    localparam int RTW   = lav_pkg::RTW;
    localparam int SQ_ST = lav_pkg::SQ_ST;
    localparam int DV_ST = lav_pkg::DV_ST;
    localparam int DRW   = lav_pkg::DRW;
    localparam int QW    = lav_pkg::QW;
    localparam int NNW   = lav_pkg::NNW;
    localparam int FB    = lav_pkg::FRAC_BITS;

    lav_pkg::nmag_vec_t  ps_mag;
    logic [2:0]          ps_sgn;
    logic                ps_zero;

    logic [2:0][SQW-1:0] sq3_reg;
    lav_pkg::nmag_vec_t  w3_reg;
    logic [2:0]          s3_reg;
    logic                z3_reg;

    logic [XW-1:0]       sx_reg    [0:SQ_ST];
    logic [RMW-1:0]      srem_reg  [0:SQ_ST];
    logic [RTW-1:0]      sroot_reg [0:SQ_ST];
    lav_pkg::nmag_vec_t  sw_reg    [0:SQ_ST];
    logic [2:0]          ss_reg    [0:SQ_ST];
    logic                sz_reg    [0:SQ_ST];

    logic [2:0][DRW-1:0] dr_reg [0:DV_ST];
    logic [2:0][QW-1:0]  dn_reg [0:DV_ST];
    logic [2:0][QW-1:0]  dq_reg [0:DV_ST];
    logic [RTW-1:0]      dl_reg [0:DV_ST];
    logic [2:0]          ds_reg [0:DV_ST];
    logic                dz_reg [0:DV_ST];

    logic [2:0][NNW-1:0] num;
    lav_pkg::unit_vec_t  u_reg;
    logic                uz_reg;

    lav_prescale u_prescale (
        .clk  (clk),
        .adv  (adv),
        .vec  (vec),
        .mag  (ps_mag),
        .sgn  (ps_sgn),
        .zero (ps_zero)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= SQW'(ps_mag[i]) * SQW'(ps_mag[i]);
            end
            w3_reg <= ps_mag;
            s3_reg <= ps_sgn;
            z3_reg <= ps_zero;

            sx_reg[0]    <= XW'(sq3_reg[0]) + XW'(sq3_reg[1]) + XW'(sq3_reg[2]);
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            sw_reg[0]    <= w3_reg;
            ss_reg[0]    <= s3_reg;
            sz_reg[0]    <= z3_reg;
        end
    end

    for (genvar k = 0; k < SQ_ST; k++)
    begin : g_sqrt
        logic [XW-1:0]  x;
        logic [RMW-1:0] rem;
        logic [RMW-1:0] t;
        logic [RTW-1:0] root;

        always_comb
        begin
            x    = sx_reg[k];
            rem  = srem_reg[k];
            root = sroot_reg[k];
            t    = '0;
            for (int j = 0; j < lav_pkg::SQ_PER; j++)
            begin
                if (k * lav_pkg::SQ_PER + j < RTW)
                begin
                    rem = {rem[RMW-3:0], x[XW-1 -: 2]};
                    x   = x << 2;
                    t   = (RMW'(root) << 2) | RMW'(1);
                    if (rem >= t)
                    begin
                        rem  = rem - t;
                        root = {root[RTW-2:0], 1'b1};
                    end
                    else
                    begin
                        root = {root[RTW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[k+1]    <= x;
                srem_reg[k+1]  <= rem;
                sroot_reg[k+1] <= root;
                sw_reg[k+1]    <= sw_reg[k];
                ss_reg[k+1]    <= ss_reg[k];
                sz_reg[k+1]    <= sz_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = NNW'({sw_reg[SQ_ST][i], {FB{1'b0}}}) + NNW'(sroot_reg[SQ_ST] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dr_reg[0][i] <= DRW'(num[i][NNW-1:QW]);
                dn_reg[0][i] <= num[i][QW-1:0];
                dq_reg[0][i] <= '0;
            end
            dl_reg[0] <= sroot_reg[SQ_ST];
            ds_reg[0] <= ss_reg[SQ_ST];
            dz_reg[0] <= sz_reg[SQ_ST];
        end
    end

    for (genvar k = 0; k < DV_ST; k++)
    begin : g_div
        logic [2:0][DRW-1:0] r;
        logic [2:0][QW-1:0]  n;
        logic [2:0][QW-1:0]  q;

        always_comb
        begin
            r = dr_reg[k];
            n = dn_reg[k];
            q = dq_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < lav_pkg::DV_PER; j++)
                begin
                    if (k * lav_pkg::DV_PER + j < QW)
                    begin
                        r[i] = {r[i][DRW-2:0], n[i][QW-1]};
                        n[i] = n[i] << 1;
                        q[i] = q[i] << 1;
                        if (r[i] >= DRW'(dl_reg[k]))
                        begin
                            r[i]    = r[i] - DRW'(dl_reg[k]);
                            q[i][0] = 1'b1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[k+1] <= r;
                dn_reg[k+1] <= n;
                dq_reg[k+1] <= q;
                dl_reg[k+1] <= dl_reg[k];
                ds_reg[k+1] <= ds_reg[k];
                dz_reg[k+1] <= dz_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (ds_reg[DV_ST][i])
                begin
                    u_reg[i] <= lav_pkg::UW'(0) - lav_pkg::UW'(dq_reg[DV_ST][i]);
                end
                else
                begin
                    u_reg[i] <= lav_pkg::UW'(dq_reg[DV_ST][i]);
                end
            end
            uz_reg <= dz_reg[DV_ST];
        end
    end

    assign unit = u_reg;
    assign zero = uz_reg;

endmodule

// ----- rtl/lookat_view_matrix.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds a right-handed view matrix from eye, target and up vectors in
// signed fixed point and sends it out as four column items.
// ----------------------------------------------------------------------------
// An item is accepted at most once per cycle, while req_stall is low, and comes
// out on the result port as four columns, one per cycle unless rsp_stall holds
// them. The pipeline holds an item in every stage, so new items enter before
// earlier ones are out; the sustained rate is set by the four columns that each
// item puts on the one-column-per-cycle result channel.
// Each of the two normalizers is a chain of square-root and division stages
// that sets most of the latency.
module lookat_view_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  lav_pkg::lav_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output lav_pkg::lav_out_t rsp
);

    localparam int N   = lav_pkg::NORM_LAT;
    localparam int TL  = lav_pkg::TOP_LAT;
    localparam int IW  = lav_pkg::IW;
    localparam int UW  = lav_pkg::UW;
    localparam int NW  = lav_pkg::NW;
    localparam int PRW = lav_pkg::PRW;
    localparam int YPW = lav_pkg::YPW;
    localparam int YRW = lav_pkg::YRW;
    localparam int DPW = lav_pkg::DPW;
    localparam int DSW = lav_pkg::DSW;
    localparam int FB  = lav_pkg::FRAC_BITS;
    localparam logic [FB-1:0] HALF = FB'(1) << (FB - 1);

    logic adv;
    logic ser_take;
    logic vld_reg [0:TL-1];

    lav_pkg::coord_vec_t eye_reg [0:2*N+5];
    lav_pkg::wide_vec_t  diff_reg;
    lav_pkg::wide_vec_t  up_reg;

    lav_pkg::unit_vec_t  zx;
    logic                zx_zero;
    lav_pkg::nmag_vec_t  upm;
    logic [2:0]          ups;
    logic                upz;

    lav_pkg::nmag_vec_t  udm_reg [0:N-3];
    logic [2:0]          uds_reg [0:N-3];
    logic                udz_reg [0:N-3];

    logic signed [NW:0]    ua [0:2];
    logic signed [PRW-1:0] pr_reg [0:5];
    logic                  dg_reg [0:N+1];
    lav_pkg::wide_vec_t    raw_reg;

    lav_pkg::unit_vec_t  xx;
    logic                xx_zero;
    lav_pkg::unit_vec_t  zd_reg [0:N+6];
    lav_pkg::unit_vec_t  xd_reg [0:4];
    logic                dd_reg [0:4];

    logic signed [YPW-1:0] yp_reg [0:5];
    logic signed [YRW-1:0] yr_reg [0:2];
    logic [YRW-1:0]        ymag   [0:2];
    logic [YRW-1:0]        yrnd   [0:2];
    lav_pkg::unit_vec_t    yx_reg [0:2];

    lav_pkg::unit_vec_t    axis   [0:2];
    logic signed [DPW-1:0] dp_reg [0:8];
    logic signed [DSW-1:0] ds_reg [0:2];
    logic signed [DSW-1:0] hs     [0:2];
    logic signed [DSW-1:0] tr     [0:2];
    logic                  inc    [0:2];

    lav_pkg::matrix_t mt_next;
    lav_pkg::matrix_t mt_reg;
    logic             mdg_reg;

    logic             ser_valid_reg;
    logic [1:0]       col_reg;
    lav_pkg::matrix_t sm_reg;
    logic             sdg_reg;

    assign ser_take  = !ser_valid_reg || (!rsp_stall && col_reg == lav_pkg::LAST_COL);
    assign adv       = !vld_reg[TL-1] || ser_take;
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= req_valid;
            for (int k = 1; k < TL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye_reg[0] <= {req.eye_z, req.eye_y, req.eye_x};
            diff_reg[0] <= IW'($signed(req.eye_x)) - IW'($signed(req.target_x));
            diff_reg[1] <= IW'($signed(req.eye_y)) - IW'($signed(req.target_y));
            diff_reg[2] <= IW'($signed(req.eye_z)) - IW'($signed(req.target_z));
            up_reg[0]   <= IW'($signed(req.up_x));
            up_reg[1]   <= IW'($signed(req.up_y));
            up_reg[2]   <= IW'($signed(req.up_z));
            for (int k = 1; k <= 2 * N + 5; k++)
            begin
                eye_reg[k] <= eye_reg[k-1];
            end
        end
    end

    lav_norm u_norm_z (
        .clk  (clk),
        .adv  (adv),
        .vec  (diff_reg),
        .unit (zx),
        .zero (zx_zero)
    );

    lav_prescale u_prescale_up (
        .clk  (clk),
        .adv  (adv),
        .vec  (up_reg),
        .mag  (upm),
        .sgn  (ups),
        .zero (upz)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            udm_reg[0] <= upm;
            uds_reg[0] <= ups;
            udz_reg[0] <= upz;
            for (int k = 1; k <= N - 3; k++)
            begin
                udm_reg[k] <= udm_reg[k-1];
                uds_reg[k] <= uds_reg[k-1];
                udz_reg[k] <= udz_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (uds_reg[N-3][i])
            begin
                ua[i] = (NW + 1)'(0) - $signed({1'b0, udm_reg[N-3][i]});
            end
            else
            begin
                ua[i] = $signed({1'b0, udm_reg[N-3][i]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg[0] <= ua[1] * $signed(zx[2]);
            pr_reg[1] <= ua[2] * $signed(zx[1]);
            pr_reg[2] <= ua[2] * $signed(zx[0]);
            pr_reg[3] <= ua[0] * $signed(zx[2]);
            pr_reg[4] <= ua[0] * $signed(zx[1]);
            pr_reg[5] <= ua[1] * $signed(zx[0]);
            dg_reg[0] <= zx_zero | udz_reg[N-3];
            for (int k = 1; k <= N + 1; k++)
            begin
                dg_reg[k] <= dg_reg[k-1];
            end
            raw_reg[0] <= IW'(pr_reg[0]) - IW'(pr_reg[1]);
            raw_reg[1] <= IW'(pr_reg[2]) - IW'(pr_reg[3]);
            raw_reg[2] <= IW'(pr_reg[4]) - IW'(pr_reg[5]);
        end
    end

    lav_norm u_norm_x (
        .clk  (clk),
        .adv  (adv),
        .vec  (raw_reg),
        .unit (xx),
        .zero (xx_zero)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zd_reg[0] <= zx;
            for (int k = 1; k <= N + 6; k++)
            begin
                zd_reg[k] <= zd_reg[k-1];
            end
            xd_reg[0] <= xx;
            dd_reg[0] <= dg_reg[N+1] | xx_zero;
            for (int k = 1; k <= 4; k++)
            begin
                xd_reg[k] <= xd_reg[k-1];
                dd_reg[k] <= dd_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yp_reg[0] <= $signed(zd_reg[N+1][1]) * $signed(xx[2]);
            yp_reg[1] <= $signed(zd_reg[N+1][2]) * $signed(xx[1]);
            yp_reg[2] <= $signed(zd_reg[N+1][2]) * $signed(xx[0]);
            yp_reg[3] <= $signed(zd_reg[N+1][0]) * $signed(xx[2]);
            yp_reg[4] <= $signed(zd_reg[N+1][0]) * $signed(xx[1]);
            yp_reg[5] <= $signed(zd_reg[N+1][1]) * $signed(xx[0]);
            for (int i = 0; i < 3; i++)
            begin
                yr_reg[i] <= YRW'(yp_reg[2*i]) - YRW'(yp_reg[2*i+1]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ymag[i] = yr_reg[i][YRW-1] ? (~yr_reg[i] + 1'b1) : yr_reg[i];
            yrnd[i] = (ymag[i] + YRW'(HALF)) >> FB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (yr_reg[i][YRW-1])
                begin
                    yx_reg[0][i] <= UW'(0) - UW'(yrnd[i]);
                end
                else
                begin
                    yx_reg[0][i] <= UW'(yrnd[i]);
                end
            end
            yx_reg[1] <= yx_reg[0];
            yx_reg[2] <= yx_reg[1];
        end
    end

    assign axis[0] = xd_reg[2];
    assign axis[1] = yx_reg[0];
    assign axis[2] = zd_reg[N+4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp_reg[3*a+i] <= $signed(axis[a][i]) * $signed(eye_reg[2*N+5][i]);
                end
                ds_reg[a] <= DSW'(dp_reg[3*a]) + DSW'(dp_reg[3*a+1]) + DSW'(dp_reg[3*a+2]);
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            hs[a]  = ds_reg[a] >>> FB;
            inc[a] = hs[a][DSW-1] ? (ds_reg[a][FB-1:0] > HALF)
                                  : (ds_reg[a][FB-1:0] >= HALF);
            tr[a]  = DSW'(0) - (hs[a] + DSW'(inc[a]));
        end
        mt_next = '0;
        if (!dd_reg[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                mt_next[c][0] = lav_pkg::sat_coord(DSW'($signed(xd_reg[4][c])));
                mt_next[c][1] = lav_pkg::sat_coord(DSW'($signed(yx_reg[2][c])));
                mt_next[c][2] = lav_pkg::sat_coord(DSW'($signed(zd_reg[N+6][c])));
                mt_next[c][3] = '0;
                mt_next[3][c] = lav_pkg::sat_coord(tr[c]);
            end
            mt_next[3][3] = lav_pkg::ONE_ENTRY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mt_reg  <= mt_next;
            mdg_reg <= dd_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else
        begin
            if (ser_valid_reg && !rsp_stall)
            begin
                col_reg <= col_reg + 2'd1;
                if (col_reg == lav_pkg::LAST_COL)
                begin
                    ser_valid_reg <= 1'b0;
                end
            end
            if (vld_reg[TL-1] && ser_take)
            begin
                ser_valid_reg <= 1'b1;
                col_reg       <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[TL-1] && ser_take)
        begin
            sm_reg  <= mt_reg;
            sdg_reg <= mdg_reg;
        end
    end

    assign rsp_valid        = ser_valid_reg;
    assign rsp.column_index = col_reg;
    assign rsp.entry_row0   = sm_reg[col_reg][0];
    assign rsp.entry_row1   = sm_reg[col_reg][1];
    assign rsp.entry_row2   = sm_reg[col_reg][2];
    assign rsp.entry_row3   = sm_reg[col_reg][3];
    assign rsp.last_column  = (col_reg == lav_pkg::LAST_COL);
    assign rsp.degenerate   = sdg_reg;

endmodule

// ----- rtl/lav_checker.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix: port checker
// Concurrent checks on the column items and their flags at the block's ports.
// ----------------------------------------------------------------------------
module lav_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input lav_pkg::lav_out_t rsp
);

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !rsp.last_column) |=>
        (rsp_valid && rsp.column_index == $past(rsp.column_index) + 2'd1))
        else $error("Column items of one matrix are not consecutive.");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.last_column == (rsp.column_index == lav_pkg::LAST_COL)))
        else $error("Last-column flag disagrees with the column index.");

    a_degen_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !rsp.last_column) |=>
        (rsp.degenerate == $past(rsp.degenerate)))
        else $error("Degenerate flag changed within one matrix.");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.degenerate) |->
        (rsp.entry_row0 == '0 && rsp.entry_row1 == '0 &&
         rsp.entry_row2 == '0 && rsp.entry_row3 == '0))
        else $error("Degenerate matrix has a nonzero entry.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("Stalled result item changed.");

endmodule

bind lookat_view_matrix lav_checker u_lav_checker (.*);
